// ===== rtl/core/ffpc_pkg.sv =====
// Shared types and constants for the flat-field pixel correction block.
// No dependencies; used by ffpc_div and flat_field_pixel_correct.
package ffpc_pkg;

   localparam int CFG_BITS   = 16;
   localparam int CSR_IDX_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_DARK_FLOOR    = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FLAT_PEAK     = 8'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUTPUT_OFFSET = 8'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_PIXEL     = 8'd3;

   localparam logic [CFG_BITS-1:0] RST_DARK_FLOOR    = 16'd4100;
   localparam logic [CFG_BITS-1:0] RST_FLAT_PEAK     = 16'd0;
   localparam logic [CFG_BITS-1:0] RST_OUTPUT_OFFSET = 16'd4000;
   localparam logic [CFG_BITS-1:0] RST_MAX_PIXEL     = 16'd255;

   typedef struct packed {
      logic neg;
      logic no_flat;
   } ffpc_tag_type;

endpackage

// ===== rtl/core/ffpc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ffpc_pkg for the sideband tag type and the divisor width.
module ffpc_div #(
   parameter int DIVIDEND_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  ffpc_pkg::ffpc_tag_type         in_tag,
   input  logic [DIVIDEND_BITS-1:0]       in_dividend,
   input  logic [ffpc_pkg::CFG_BITS-1:0]  in_divisor,
   output logic                           out_valid,
   output ffpc_pkg::ffpc_tag_type         out_tag,
   output logic [DIVIDEND_BITS-1:0]       out_quot
);

   localparam int DB = ffpc_pkg::CFG_BITS;

   logic                   valid_ff [DIVIDEND_BITS];
   ffpc_pkg::ffpc_tag_type tag_ff   [DIVIDEND_BITS];
   logic [DB-1:0]          rem_ff   [DIVIDEND_BITS];
   logic [DIVIDEND_BITS-1:0] dq_ff  [DIVIDEND_BITS];
   logic [DB-1:0]          div_ff   [DIVIDEND_BITS];

   for (genvar i = 0; i < DIVIDEND_BITS; i++) begin : g_stage
      logic                     prev_valid;
      ffpc_pkg::ffpc_tag_type   prev_tag;
      logic [DB-1:0]            prev_rem;
      logic [DIVIDEND_BITS-1:0] prev_dq;
      logic [DB-1:0]            prev_div;
      logic [DB+1:0]            trial;
      logic                     ge;
      logic [DB-1:0]            rem_in;
      logic [DIVIDEND_BITS-1:0] dq_in;

      if (i == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_tag   = in_tag;
         assign prev_rem   = '0;
         assign prev_dq    = in_dividend;
         assign prev_div   = in_divisor;
      end else begin : g_next
         assign prev_valid = valid_ff[i-1];
         assign prev_tag   = tag_ff[i-1];
         assign prev_rem   = rem_ff[i-1];
         assign prev_dq    = dq_ff[i-1];
         assign prev_div   = div_ff[i-1];
      end

      always_comb begin
         trial  = {1'b0, prev_rem, prev_dq[DIVIDEND_BITS-1]} - {2'b00, prev_div};
         ge     = ~trial[DB+1];
         rem_in = ge ? trial[DB-1:0] : {prev_rem[DB-2:0], prev_dq[DIVIDEND_BITS-1]};
         dq_in  = {prev_dq[DIVIDEND_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= prev_valid;
         end
         if (en) begin
            tag_ff[i] <= prev_tag;
            rem_ff[i] <= rem_in;
            dq_ff[i]  <= dq_in;
            div_ff[i] <= prev_div;
         end
      end
   end

   assign out_valid = valid_ff[DIVIDEND_BITS-1];
   assign out_tag   = tag_ff[DIVIDEND_BITS-1];
   assign out_quot  = dq_ff[DIVIDEND_BITS-1];

endmodule

// ===== rtl/core/flat_field_pixel_correct.sv =====
// Top level of the flat-field pixel correction block.
// Depends on ffpc_pkg and ffpc_div.
//
// Usage: each req_ transaction carries a raw pixel, its bias value and its
// flat value; each yields exactly one rsp_ transaction, in order, with the
// corrected pixel clamped to 0..max_pixel, or 0 with rsp_no_flat set when the
// flat value is not above the dark floor register.
// Pipeline: one stage for the differences, one for the gain multiply,
// one divider stage per quotient bit (SAMPLE_BITS + 16), one for the sign
// and one for the offset add and clamp into the output register.
// Throughput: one pixel per cycle when not stalled (divider fully pipelined).
// Stall: the whole pipeline holds while the output register is full and
// rsp_stall is high; req_stall is raised in exactly those cycles. Bubbles
// elsewhere do not stall the input.
// Configuration: csr_ writes are always ready; write only while no pixel is
// in flight. Indexes past max_pixel are ignored.
// Reset: synchronous, clears all valid bits and loads register defaults
// (dark floor 4100, flat_peak 0, output_offset 4000, max_pixel 255).
module flat_field_pixel_correct #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [SAMPLE_BITS-1:0]               req_raw_sample,
   input  logic [SAMPLE_BITS-1:0]               req_bias_sample,
   input  logic [SAMPLE_BITS-1:0]               req_flat_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_corrected,
   output logic                                 rsp_no_flat,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ffpc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ffpc_pkg::CFG_BITS-1:0]        csr_wdata
);

   localparam int CB = ffpc_pkg::CFG_BITS;
   localparam int DW = SAMPLE_BITS + CB;

   logic [CB-1:0] dark_floor_ff;
   logic [CB-1:0] flat_peak_ff;
   logic [CB-1:0] output_offset_ff;
   logic [CB-1:0] max_pixel_ff;

   logic en;

   // difference stage
   logic                   s1_valid_ff;
   ffpc_pkg::ffpc_tag_type s1_tag_ff;
   logic [SAMPLE_BITS-1:0] s1_mag_ff;
   logic [CB-1:0]          s1_denom_ff;
   logic [CB-1:0]          flat_ext;
   ffpc_pkg::ffpc_tag_type s1_tag_in;
   logic [SAMPLE_BITS-1:0] s1_mag_in;
   logic [CB-1:0]          s1_denom_in;

   // multiply stage
   logic                   s2_valid_ff;
   ffpc_pkg::ffpc_tag_type s2_tag_ff;
   logic [DW-1:0]          s2_prod_ff;
   logic [CB-1:0]          s2_denom_ff;

   // divider output
   logic                   dv_valid;
   ffpc_pkg::ffpc_tag_type dv_tag;
   logic [DW-1:0]          dv_quot;

   // sign stage
   logic                   s3_valid_ff;
   logic                   s3_no_flat_ff;
   logic signed [DW:0]     s3_quot_ff;

   // output stage
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_corrected_ff;
   logic                   rsp_no_flat_ff;
   logic signed [DW+1:0]   sum;
   logic [15:0]            corrected_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_floor_ff    <= ffpc_pkg::RST_DARK_FLOOR;
         flat_peak_ff     <= ffpc_pkg::RST_FLAT_PEAK;
         output_offset_ff <= ffpc_pkg::RST_OUTPUT_OFFSET;
         max_pixel_ff     <= ffpc_pkg::RST_MAX_PIXEL;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ffpc_pkg::REG_DARK_FLOOR:    dark_floor_ff    <= csr_wdata;
            ffpc_pkg::REG_FLAT_PEAK:     flat_peak_ff     <= csr_wdata;
            ffpc_pkg::REG_OUTPUT_OFFSET: output_offset_ff <= csr_wdata;
            ffpc_pkg::REG_MAX_PIXEL:     max_pixel_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;

   always_comb begin
      flat_ext          = CB'(req_flat_sample);
      s1_tag_in.neg     = req_raw_sample < req_bias_sample;
      s1_tag_in.no_flat = flat_ext <= dark_floor_ff;
      s1_mag_in = s1_tag_in.neg ? req_bias_sample - req_raw_sample
                                : req_raw_sample - req_bias_sample;
      s1_denom_in = s1_tag_in.no_flat ? CB'(1) : flat_ext - dark_floor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= dv_valid;
         rsp_valid_ff <= s3_valid_ff;
      end
      if (en) begin
         s1_tag_ff   <= s1_tag_in;
         s1_mag_ff   <= s1_mag_in;
         s1_denom_ff <= s1_denom_in;
         s2_tag_ff   <= s1_tag_ff;
         s2_prod_ff  <= DW'(s1_mag_ff) * DW'(flat_peak_ff);
         s2_denom_ff <= s1_denom_ff;
         s3_no_flat_ff <= dv_tag.no_flat;
         s3_quot_ff    <= dv_tag.neg ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
         rsp_corrected_ff <= corrected_in;
         rsp_no_flat_ff   <= s3_no_flat_ff;
      end
   end

   ffpc_div #(
      .DIVIDEND_BITS (DW)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s2_valid_ff),
      .in_tag      (s2_tag_ff),
      .in_dividend (s2_prod_ff),
      .in_divisor  (s2_denom_ff),
      .out_valid   (dv_valid),
      .out_tag     (dv_tag),
      .out_quot    (dv_quot)
   );

   always_comb begin
      sum = (DW+2)'(s3_quot_ff) + $signed({2'b00, DW'(output_offset_ff)});
      priority if (s3_no_flat_ff || sum[DW+1]) begin
         corrected_in = '0;
      end else if (sum > $signed({2'b00, DW'(max_pixel_ff)})) begin
         corrected_in = max_pixel_ff;
      end else begin
         corrected_in = sum[15:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_corrected = rsp_corrected_ff;
   assign rsp_no_flat   = rsp_no_flat_ff;

   a_no_flat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_flat |-> rsp_corrected == 16'd0)
      else $error("no_flat result with nonzero pixel");

   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_corrected <= max_pixel_ff)
      else $error("corrected pixel above max_pixel");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
